### design/lpi_pkg.sv
package lpi_pkg;

	// hit counter
	localparam int COUNT_W = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// entries in the queue between the front and the back
	localparam int QUEUE_DEPTH = 2;

	// register map: four 32-bit registers at byte address 4*index
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_START_Y = 2'd1;
	localparam logic [1:0] REG_END_X   = 2'd2;
	localparam logic [1:0] REG_END_Y   = 2'd3;

	localparam int START_X_RST = 0;
	localparam int START_Y_RST = 0;
	localparam int END_X_RST   = 6963;
	localparam int END_Y_RST   = 4096;

endpackage

### design/line_polyline_intersect.sv
// Line / polyline intersection.
// s_* carries polyline vertices: tdata = vertex_x, vertex_y; tuser = first_vertex,
// which starts a new polyline and clears the hit count. Every vertex after the
// first closes a segment, which is tested against the line held in the four
// APB registers (start x/y at 0x0/0x4, end x/y at 0x8/0xC).
// m_* returns exactly one word per vertex: tuser = hit; tdata = point_x, point_y,
// hit_count. The point is zero when hit is low; the count saturates.
// A vertex that closes a crossing segment holds the back end while it steps through
// leaving the queue, two side products, a check, two offset products, a divider start,
// the radix-2 divider steps and done flag, and loading the output; the back end takes
// no new vertex before it is through with the last one.
// A two-entry queue sits between the vertex front end and the back end, so vertices
// keep being taken while a result waits in the output register. When m_tready is
// low the back end holds its finished word, the queue fills and s_tready drops.
// Reset clears the previous vertex, the hit count, the queue and the output, and
// loads the line registers with start (0, 0) and end (6963, 4096).
// Write the line registers only while no vertex is in flight.
module line_polyline_intersect #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// vertex_x, vertex_y
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
	// first_vertex
	input  logic [0:0]                             s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// point_x, point_y, hit_count, zero fill
	output logic [((2*COORD_WIDTH+lpi_pkg::COUNT_W+7)/8)*8-1:0] m_tdata,
	// hit
	output logic [0:0]                             m_tuser,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [lpi_pkg::ADDR_W-1:0]             paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);
	import lpi_pkg::*;

	localparam int W      = COORD_WIDTH;
	localparam int JOB_W  = 6 * W + 4;
	localparam int OUT_DW = ((2 * W + COUNT_W + 7) / 8) * 8;

	logic signed [W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic                cfg_wr;
	logic [1:0]          reg_idx;

	logic                push, q_full, q_valid, q_pop;
	logic [JOB_W-1:0]    job_w, job_r;

	logic                out_hit;
	logic signed [W-1:0] out_px, out_py;
	logic [COUNT_W-1:0]  out_count;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= W'(START_X_RST);
			start_y_q <= W'(START_Y_RST);
			end_x_q   <= W'(END_X_RST);
			end_y_q   <= W'(END_Y_RST);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_START_X: start_x_q <= pwdata[W-1:0];
				REG_START_Y: start_y_q <= pwdata[W-1:0];
				REG_END_X:   end_x_q   <= pwdata[W-1:0];
				REG_END_Y:   end_y_q   <= pwdata[W-1:0];
				default:     start_x_q <= start_x_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_START_X: prdata = 32'(start_x_q);
			REG_START_Y: prdata = 32'(start_y_q);
			REG_END_X:   prdata = 32'(end_x_q);
			REG_END_Y:   prdata = 32'(end_y_q);
			default:     prdata = '0;
		endcase
	end

	lpi_front #(
		.W (W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_valid      (s_tvalid),
		.s_ready      (s_tready),
		.vertex_x     (s_tdata[W-1:0]),
		.vertex_y     (s_tdata[2*W-1:W]),
		.first_vertex (s_tuser[0]),
		.q_full       (q_full),
		.push         (push),
		.job          (job_w)
	);

	lpi_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (job_w),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rdata     (job_r)
	);

	lpi_back #(
		.W (W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.line_start_x (start_x_q),
		.line_start_y (start_y_q),
		.line_end_x   (end_x_q),
		.line_end_y   (end_y_q),
		.job_valid    (q_valid),
		.job          (job_r),
		.job_pop      (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_hit      (out_hit),
		.out_px       (out_px),
		.out_py       (out_py),
		.out_count    (out_count)
	);

	assign m_tdata    = OUT_DW'({out_count, out_py, out_px});
	assign m_tuser[0] = out_hit;

endmodule

### design/lpi_fifo.sv
module lpi_fifo #(
	parameter int WIDTH = 100,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);

	// DEPTH must be a power of two so the pointers wrap on their own; the block does not check it
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CNTW-1:0]  cnt_q;

	assign full      = (cnt_q == CNTW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + AW'(1);
			if (pop)
				rd_q <= rd_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNTW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

endmodule

### design/lpi_front.sv
module lpi_front #(
	parameter int W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_valid,
	output logic                s_ready,
	input  logic signed [W-1:0] vertex_x,
	input  logic signed [W-1:0] vertex_y,
	input  logic                first_vertex,
	input  logic                q_full,
	output logic                push,
	output logic [6*W+3:0]      job
);

	typedef struct packed {
		logic              seg;
		logic              clr;
		logic signed [W-1:0] p1x;
		logic signed [W-1:0] p1y;
		logic signed [W-1:0] p2x;
		logic signed [W-1:0] p2y;
		logic signed [W:0]   dtx;
		logic signed [W:0]   dty;
	} job_t;

	logic                have_prev_q;
	logic signed [W-1:0] prev_x_q;
	logic signed [W-1:0] prev_y_q;
	job_t                job_s;

	assign s_ready = !q_full;
	assign push    = s_valid && !q_full;

	// a vertex closes a segment only when a previous one exists in this polyline
	always_comb begin
		job_s.seg = have_prev_q && !first_vertex;
		job_s.clr = first_vertex;
		job_s.p1x = prev_x_q;
		job_s.p1y = prev_y_q;
		job_s.p2x = vertex_x;
		job_s.p2y = vertex_y;
		job_s.dtx = (W+1)'(vertex_x) - (W+1)'(prev_x_q);
		job_s.dty = (W+1)'(vertex_y) - (W+1)'(prev_y_q);
	end

	assign job = job_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
		end else if (push) begin
			have_prev_q <= 1'b1;
			prev_x_q    <= vertex_x;
			prev_y_q    <= vertex_y;
		end
	end

endmodule

### design/lpi_div.sv
module lpi_div #(
	parameter int NW = 52,
	parameter int DW = 36,
	parameter int QB = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] nx,
	input  logic [NW-1:0] ny,
	input  logic [DW-1:0] d,
	output logic          busy,
	output logic          done,
	output logic [QB-1:0] qx,
	output logic [QB-1:0] qy
);

	localparam int CW = $clog2(QB + 1);

	// the upper part of the dividend is below d, so QB steps give the whole quotient
	logic [DW-1:0] rx_q, ry_q;
	logic [QB-1:0] shx_q, shy_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   tx, ty, dd;
	logic          gex, gey;

	assign dd  = {1'b0, d};
	assign tx  = {rx_q, shx_q[QB-1]};
	assign ty  = {ry_q, shy_q[QB-1]};
	assign gex = (tx >= dd);
	assign gey = (ty >= dd);

	assign busy = busy_q;
	assign done = done_q;
	assign qx   = shx_q;
	assign qy   = shy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder shifts in one dividend bit a step; quotient bits fill in behind it
	always_ff @(posedge clk) begin
		if (start) begin
			rx_q  <= DW'(nx >> QB);
			ry_q  <= DW'(ny >> QB);
			shx_q <= nx[QB-1:0];
			shy_q <= ny[QB-1:0];
		end else if (busy_q) begin
			rx_q  <= gex ? DW'(tx - dd) : tx[DW-1:0];
			ry_q  <= gey ? DW'(ty - dd) : ty[DW-1:0];
			shx_q <= {shx_q[QB-2:0], gex};
			shy_q <= {shy_q[QB-2:0], gey};
		end
	end

endmodule

### design/lpi_back.sv
module lpi_back #(
	parameter int W = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic signed [W-1:0]             line_start_x,
	input  logic signed [W-1:0]             line_start_y,
	input  logic signed [W-1:0]             line_end_x,
	input  logic signed [W-1:0]             line_end_y,
	input  logic                            job_valid,
	input  logic [6*W+3:0]                  job,
	output logic                            job_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_hit,
	output logic signed [W-1:0]             out_px,
	output logic signed [W-1:0]             out_py,
	output logic [lpi_pkg::COUNT_W-1:0]     out_count
);
	import lpi_pkg::*;

	localparam int A   = W + 2;       // multiplier operand
	localparam int PW  = 2 * A;       // product, side value
	localparam int AFW = 2 * W + 2;   // |f1|
	localparam int ADW = 2 * W + 3;   // |f1 - f2|
	localparam int DW  = 2 * W + 4;   // divisor 2|den|
	localparam int QB  = W + 1;       // quotient bits
	localparam int NW  = 3 * W + 4;   // dividend 2|f1||delta| + |den|

	typedef struct packed {
		logic              seg;
		logic              clr;
		logic signed [W-1:0] p1x;
		logic signed [W-1:0] p1y;
		logic signed [W-1:0] p2x;
		logic signed [W-1:0] p2y;
		logic signed [W:0]   dtx;
		logic signed [W:0]   dty;
	} job_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MUL1  = 9'b000000010,
		ST_MUL2  = 9'b000000100,
		ST_CHK   = 9'b000001000,
		ST_MULLO = 9'b000010000,
		ST_MULHI = 9'b000100000,
		ST_DIVST = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t              state_q;
	job_t                job_in, job_q;
	logic [COUNT_W-1:0]  count_q;

	logic signed [W:0]   ldx, ldy, r1x, r1y, r2x, r2y;
	logic signed [A-1:0] op_ax, op_ay, op_bx, op_by;
	logic signed [PW-1:0] ma_q, mb_q, f1_q, f2, den, af_full, ad_full;
	logic                f1_neg, f2_neg, f1_zero, f2_zero, straddle, cand;
	logic [AFW-1:0]      af_q;
	logic [ADW-1:0]      ad_q;
	logic [W:0]          adx_q, ady_q;
	logic [NW-1:0]       nlo_x_q, nlo_y_q, div_nx, div_ny;
	logic [DW-1:0]       div_d;
	logic                div_start, div_busy, div_done;
	logic [QB-1:0]       qx, qy;
	logic [W+1:0]        sum_x, sum_y;
	logic signed [W-1:0] ix, iy, box_x_lo, box_x_hi, box_y_lo, box_y_hi;
	logic                hit_now;

	logic                res_hit_q;
	logic signed [W-1:0] res_px_q, res_py_q;
	logic                out_valid_q, out_hit_q;
	logic signed [W-1:0] out_px_q, out_py_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic                out_load;

	assign job_in  = job;
	assign job_pop = (state_q == ST_IDLE) && job_valid;

	assign ldx = (W+1)'(line_end_x) - (W+1)'(line_start_x);
	assign ldy = (W+1)'(line_end_y) - (W+1)'(line_start_y);
	assign r1x = (W+1)'(job_q.p1x) - (W+1)'(line_start_x);
	assign r1y = (W+1)'(job_q.p1y) - (W+1)'(line_start_y);
	assign r2x = (W+1)'(job_q.p2x) - (W+1)'(line_start_x);
	assign r2y = (W+1)'(job_q.p2y) - (W+1)'(line_start_y);

	// two multipliers: side terms first, then |f1| times |delta| in two halves
	always_comb begin
		op_ax = '0;
		op_ay = '0;
		op_bx = '0;
		op_by = '0;
		unique case (state_q)
			ST_MUL1: begin
				op_ax = A'(ldy);
				op_ay = A'(r1x);
				op_bx = A'(ldx);
				op_by = A'(r1y);
			end
			ST_MUL2: begin
				op_ax = A'(ldy);
				op_ay = A'(r2x);
				op_bx = A'(ldx);
				op_by = A'(r2y);
			end
			ST_MULLO: begin
				op_ax = A'(af_q[W:0]);
				op_ay = A'(adx_q);
				op_bx = A'(af_q[W:0]);
				op_by = A'(ady_q);
			end
			ST_MULHI: begin
				op_ax = A'(af_q[AFW-1:W+1]);
				op_ay = A'(adx_q);
				op_bx = A'(af_q[AFW-1:W+1]);
				op_by = A'(ady_q);
			end
			default: begin
				op_ax = '0;
			end
		endcase
	end

	// crossing test on the two side values
	assign f2       = ma_q - mb_q;
	assign f1_neg   = f1_q[PW-1];
	assign f2_neg   = f2[PW-1];
	assign f1_zero  = (f1_q == '0);
	assign f2_zero  = (f2 == '0);
	assign straddle = (f1_neg || f1_zero) ? (!f2_neg || f2_zero) : (f2_neg || f2_zero);
	assign cand     = (f1_q != f2) && straddle;
	assign den      = f1_q - f2;
	assign af_full  = f1_neg ? -f1_q : f1_q;
	assign ad_full  = den[PW-1] ? -den : den;

	// round to nearest: (2|f1||delta| + |den|) / (2|den|)
	assign div_nx    = nlo_x_q + (NW'(ma_q[AFW-1:0]) << (W + 2));
	assign div_ny    = nlo_y_q + (NW'(mb_q[AFW-1:0]) << (W + 2));
	assign div_d     = DW'(ad_q) << 1;
	assign div_start = (state_q == ST_DIVST);

	lpi_div #(
		.NW (NW),
		.DW (DW),
		.QB (QB)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.nx     (div_nx),
		.ny     (div_ny),
		.d      (div_d),
		.busy   (div_busy),
		.done   (div_done),
		.qx     (qx),
		.qy     (qy)
	);

	// the offset points from the earlier vertex toward the later one
	assign sum_x = (W+2)'(job_q.p1x) + (job_q.dtx[W] ? -(W+2)'(qx) : (W+2)'(qx));
	assign sum_y = (W+2)'(job_q.p1y) + (job_q.dty[W] ? -(W+2)'(qy) : (W+2)'(qy));
	assign ix    = signed'(sum_x[W-1:0]);
	assign iy    = signed'(sum_y[W-1:0]);

	assign box_x_lo = (line_start_x < line_end_x) ? line_start_x : line_end_x;
	assign box_x_hi = (line_start_x < line_end_x) ? line_end_x : line_start_x;
	assign box_y_lo = (line_start_y < line_end_y) ? line_start_y : line_end_y;
	assign box_y_hi = (line_start_y < line_end_y) ? line_end_y : line_start_y;
	assign hit_now  = (ix >= box_x_lo) && (ix <= box_x_hi) &&
	                  (iy >= box_y_lo) && (iy <= box_y_hi);

	// load the output register once it is free or being taken
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						if (job_in.clr)
							count_q <= '0;
						state_q <= job_in.seg ? ST_MUL1 : ST_DONE;
					end
				end
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_CHK;
				ST_CHK:   state_q <= cand ? ST_MULLO : ST_DONE;
				ST_MULLO: state_q <= ST_MULHI;
				ST_MULHI: state_q <= ST_DIVST;
				ST_DIVST: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						if (hit_now && count_q != COUNT_MAX)
							count_q <= count_q + COUNT_W'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q     <= job_in;
			res_hit_q <= 1'b0;
			res_px_q  <= '0;
			res_py_q  <= '0;
		end
		if (state_q == ST_MUL1 || state_q == ST_MUL2 ||
		    state_q == ST_MULLO || state_q == ST_MULHI) begin
			ma_q <= op_ax * op_ay;
			mb_q <= op_bx * op_by;
		end
		if (state_q == ST_MUL2)
			f1_q <= ma_q - mb_q;
		if (state_q == ST_CHK) begin
			af_q  <= af_full[AFW-1:0];
			ad_q  <= ad_full[ADW-1:0];
			adx_q <= job_q.dtx[W] ? -job_q.dtx : job_q.dtx;
			ady_q <= job_q.dty[W] ? -job_q.dty : job_q.dty;
		end
		if (state_q == ST_MULHI) begin
			nlo_x_q <= (NW'(ma_q[AFW-1:0]) << 1) + NW'(ad_q);
			nlo_y_q <= (NW'(mb_q[AFW-1:0]) << 1) + NW'(ad_q);
		end
		if (state_q == ST_DIV && div_done && hit_now) begin
			res_hit_q <= 1'b1;
			res_px_q  <= ix;
			res_py_q  <= iy;
		end
		if (out_load) begin
			out_hit_q   <= res_hit_q;
			out_px_q    <= res_px_q;
			out_py_q    <= res_py_q;
			out_count_q <= count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;
	assign out_px    = out_px_q;
	assign out_py    = out_py_q;
	assign out_count = out_count_q;

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVST) |-> !div_busy)
		else $error("divider started while busy");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_hit_q) |-> (out_count_q != '0))
		else $error("hit reported with zero count");

	a_count_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q < $past(count_q)) |-> $past(job_pop && job_in.clr))
		else $error("hit count dropped without a new polyline");

endmodule

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpi_pkg::*;

	localparam int CHUNKS = 31;
	localparam int CHUNK_ITEMS = 50;
	localparam int DRAIN_CYCLES = 40;
	localparam int LONG_STALL = 300;

	typedef struct {
		shortint x;
		shortint y;
		bit      first;
	} vertex_t;

	typedef struct {
		bit                 hit;
		shortint            px;
		shortint            py;
		logic [COUNT_W-1:0] count;
	} crossing_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// vertex_x, vertex_y
	logic [31:0] s_tdata = '0;
	// first_vertex
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// point_x, point_y, hit_count
	logic [47:0] m_tdata;
	// hit
	logic [0:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	line_polyline_intersect uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predictor state: line registers and polyline tracking
	shortint            line_x0 = shortint'(START_X_RST);
	shortint            line_y0 = shortint'(START_Y_RST);
	shortint            line_x1 = shortint'(END_X_RST);
	shortint            line_y1 = shortint'(END_Y_RST);
	shortint            prev_x = 0;
	shortint            prev_y = 0;
	bit                 have_prev = 1'b0;
	logic [COUNT_W-1:0] hit_total = '0;

	vertex_t   vertex_q[$];
	crossing_t crossing_q[$];
	vertex_t   accepted_v;
	vertex_t   next_v;
	crossing_t want;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit stall_request = 1'b0;
	bit recv_blocked = 1'b0;
	int mismatch_count = 0;

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint side_value(shortint px, shortint py);
		longint dxl, dyl;
		dxl = longint'(line_x1) - longint'(line_x0);
		dyl = longint'(line_y1) - longint'(line_y0);
		return dyl * (longint'(px) - longint'(line_x0)) - dxl * (longint'(py) - longint'(line_y0));
	endfunction

	// p1 + f1*(p2-p1)/den, rounded to nearest, halves away from zero
	function automatic longint round_lerp(shortint p1, shortint p2, longint f1, longint den);
		longint delta, q;
		bit neg;
		delta = longint'(p2) - longint'(p1);
		neg = (f1 < 0) ^ (delta < 0) ^ (den < 0);
		q = (2 * mag(f1) * mag(delta) + mag(den)) / (2 * mag(den));
		return neg ? longint'(p1) - q : longint'(p1) + q;
	endfunction

	function automatic bit between(longint v, shortint a, shortint b);
		longint lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return v >= lo && v <= hi;
	endfunction

	function automatic crossing_t crossing_predict(vertex_t v);
		crossing_t r;
		longint f1, f2, ix, iy;
		bit straddle;
		r.hit = 1'b0;
		r.px = 0;
		r.py = 0;
		if (v.first) begin
			hit_total = '0;
			have_prev = 1'b0;
		end
		if (have_prev) begin
			f1 = side_value(prev_x, prev_y);
			f2 = side_value(v.x, v.y);
			straddle = (f1 <= 0) ? (f2 >= 0) : (f2 <= 0);
			if (f1 != f2 && straddle) begin
				ix = round_lerp(prev_x, v.x, f1, f1 - f2);
				iy = round_lerp(prev_y, v.y, f1, f1 - f2);
				if (between(ix, line_x0, line_x1) && between(iy, line_y0, line_y1)) begin
					r.hit = 1'b1;
					r.px = shortint'(ix);
					r.py = shortint'(iy);
					if (hit_total != COUNT_MAX)
						hit_total = hit_total + 1'b1;
				end
			end
		end
		prev_x = v.x;
		prev_y = v.y;
		have_prev = 1'b1;
		r.count = hit_total;
		return r;
	endfunction

	function automatic shortint saturate_coord(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return shortint'(v);
	endfunction

	function automatic shortint rand_coord(bit narrow);
		if (narrow)
			return shortint'(int'($urandom_range(0, 16384)) - 8192);
		return shortint'($urandom);
	endfunction

	task automatic push_vertex(input shortint x, input shortint y, input bit first);
		vertex_t v;
		v.x = x;
		v.y = y;
		v.first = first;
		vertex_q.push_back(v);
	endtask

	task automatic apb_write(input logic [1:0] idx, input shortint val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_START_X: line_x0 = val;
			REG_START_Y: line_y0 = val;
			REG_END_X:   line_x1 = val;
			REG_END_Y:   line_y1 = val;
			default: ;
		endcase
	endtask

	task automatic set_line(input shortint x0, input shortint y0, input shortint x1,
			input shortint y1);
		apb_write(REG_START_X, x0);
		apb_write(REG_START_Y, y0);
		apb_write(REG_END_X, x1);
		apb_write(REG_END_Y, y1);
	endtask

	// hold until every vertex is taken and every word has come back
	task automatic wait_drained;
		do @(negedge clk); while (vertex_q.size() != 0 || s_tvalid || crossing_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// polylines that zigzag across the line, mixed with noise and broken runs
	task automatic queue_random_vertices(input int n);
		int left, run_len, mode, reach, side, i;
		longint dxl, dyl, s, k, jx, jy;
		shortint vx, vy, lastx, lasty;
		bit first;
		left = n;
		lastx = 0;
		lasty = 0;
		dxl = longint'(line_x1) - longint'(line_x0);
		dyl = longint'(line_y1) - longint'(line_y0);
		while (left > 0) begin
			run_len = $urandom_range(2, 12);
			first = ($urandom_range(0, 9) != 0);
			side = $urandom_range(0, 1) ? 1 : -1;
			case ($urandom_range(0, 2))
				0: reach = 16;
				1: reach = 256;
				default: reach = 1024;
			endcase
			for (i = 0; i < run_len && left > 0; i++) begin
				mode = $urandom_range(0, 99);
				if (mode < 65) begin
					s = $urandom_range(0, 1280);
					s -= 128;
					k = $urandom_range(0, reach);
					jx = $urandom_range(0, 8);
					jx -= 4;
					jy = $urandom_range(0, 8);
					jy -= 4;
					vx = saturate_coord(longint'(line_x0) + (dxl * s) / 1024
						- side * ((dyl * k) / 1024) + jx);
					vy = saturate_coord(longint'(line_y0) + (dyl * s) / 1024
						+ side * ((dxl * k) / 1024) + jy);
					if ($urandom_range(0, 4) != 0)
						side = -side;
				end else if (mode < 85) begin
					vx = rand_coord(1'b0);
					vy = rand_coord(1'b0);
				end else if (mode < 93) begin
					case ($urandom_range(0, 2))
						0: begin
							vx = line_x0;
							vy = line_y0;
						end
						1: begin
							vx = line_x1;
							vy = line_y1;
						end
						default: begin
							vx = shortint'((longint'(line_x0) + longint'(line_x1)) / 2);
							vy = shortint'((longint'(line_y0) + longint'(line_y1)) / 2);
						end
					endcase
				end else begin
					vx = lastx;
					vy = lasty;
				end
				push_vertex(vx, vy, (first && i == 0) || $urandom_range(0, 49) == 0);
				lastx = vx;
				lasty = vy;
				left--;
			end
		end
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("tb: FAIL");
		$finish;
	end

	// vertex driver; predict each word as its vertex is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				accepted_v.x = shortint'(s_tdata[15:0]);
				accepted_v.y = shortint'(s_tdata[31:16]);
				accepted_v.first = s_tuser[0];
				crossing_q.push_back(crossing_predict(accepted_v));
			end
			if (!s_tvalid || s_tready) begin
				if (vertex_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_v = vertex_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {next_v.y, next_v.x};
					s_tuser <= next_v.first;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= !recv_blocked && $urandom_range(0, 99) >= recv_idle_pct;
	end

	// long receiver hold-off, counted here
	always begin
		@(negedge clk);
		if (stall_request) begin
			recv_blocked = 1'b1;
			repeat (LONG_STALL) @(negedge clk);
			recv_blocked = 1'b0;
			stall_request = 1'b0;
		end
	end

	task automatic flag_mismatch(input string what, input logic [47:0] exp_v,
			input logic [47:0] act_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("tb: %s mismatch: expected %h got %h", what, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (crossing_q.size() == 0) begin
				flag_mismatch("unexpected word", '0, m_tdata);
			end else begin
				want = crossing_q.pop_front();
				if (m_tuser[0] !== want.hit)
					flag_mismatch("hit", want.hit, m_tuser);
				if (m_tdata[15:0] !== want.px)
					flag_mismatch("point_x", 16'(want.px), m_tdata[15:0]);
				if (m_tdata[31:16] !== want.py)
					flag_mismatch("point_y", 16'(want.py), m_tdata[31:16]);
				if (m_tdata[47:32] !== want.count)
					flag_mismatch("hit_count", want.count, m_tdata[47:32]);
			end
		end
	end

	initial begin
		int k;
		shortint cx, cy;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset line (0,0)-(6963,4096); start without a first-vertex flag
		push_vertex(0, 4000, 1'b0);
		push_vertex(4000, 0, 1'b0);
		push_vertex(6963, 4096, 1'b0);
		push_vertex(8000, 8000, 1'b0);
		push_vertex(8000, 8000, 1'b0);
		push_vertex(0, 1000, 1'b1);
		push_vertex(6963, 5096, 1'b0);
		push_vertex(0, 0, 1'b0);
		push_vertex(6963, 4096, 1'b0);
		push_vertex(-10000, 0, 1'b0);
		push_vertex(-10000, -10000, 1'b0);
		push_vertex(-32768, -32768, 1'b1);
		push_vertex(32767, 32767, 1'b0);
		push_vertex(32767, -32768, 1'b0);
		push_vertex(-32768, 32767, 1'b0);
		push_vertex(21845, -21846, 1'b0);
		push_vertex(-21846, 21845, 1'b0);
		push_vertex(-1, -1, 1'b0);
		push_vertex(1, 1, 1'b1);
		wait_drained();

		for (k = 0; k < CHUNKS; k++) begin
			case (k % 8)
				0: set_line(-32768, -32768, 32767, 32767);
				1: set_line(32767, -32768, -32768, 32767);
				2: begin
					cx = rand_coord(k > 8);
					set_line(cx, rand_coord(1'b0), cx, rand_coord(1'b0));
				end
				3: begin
					cy = rand_coord(k > 8);
					set_line(rand_coord(1'b0), cy, rand_coord(1'b0), cy);
				end
				4: begin
					if (k == 4) begin
						cx = rand_coord(1'b1);
						cy = rand_coord(1'b1);
						set_line(cx, cy, cx, cy);
					end else begin
						set_line(rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0),
							rand_coord(1'b0));
					end
				end
				default: set_line(rand_coord(k[0]), rand_coord(k[0]), rand_coord(k[0]),
					rand_coord(k[0]));
			endcase
			@(negedge clk);
			if (k < 10) begin
				send_idle_pct = 21;
				recv_idle_pct = 80;
			end else if (k < 20) begin
				send_idle_pct = 80;
				recv_idle_pct = 21;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			queue_random_vertices(CHUNK_ITEMS);
			// back the block up while vertices keep coming
			if (k == 20)
				stall_request = 1'b1;
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

### filelist.f
design/lpi_pkg.sv
design/lpi_fifo.sv
design/lpi_front.sv
design/lpi_div.sv
design/lpi_back.sv
design/line_polyline_intersect.sv
tb/tb.sv
